FILE: hdl/pmsfx_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the PCM mixer with sweep sound effect.
// No dependencies; every other file of the block uses this package.
package pmsfx_pkg;

    // Field and register widths
    localparam int BYTE_W     = 8;
    localparam int SAMPLE_W   = 16;
    localparam int ADDR_W     = 18;
    localparam int VOL_W      = 12;
    localparam int ELEN_W     = 16;
    localparam int LLEN_W     = 19;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 19;

    // Register reset values
    localparam logic [VOL_W-1:0]  VOLUME_RESET        = 12'd1024;
    localparam logic [ELEN_W-1:0] EFFECT_LENGTH_RESET = 16'd4410;
    localparam logic [LLEN_W-1:0] LOOP_LENGTH_RESET   = 19'd220500;

    // Mixer arithmetic constants
    localparam logic signed [8:0]  MUSIC_BIAS  = 9'sd128;
    localparam logic signed [16:0] MUSIC_GAIN  = 17'sd200;
    localparam logic [9:0]         FREQ_LOW    = 10'd200;
    localparam logic [9:0]         FREQ_HIGH   = 10'd1000;
    localparam logic [24:0]        FREQ_SPAN   = 25'd800;
    localparam logic [31:0]        SAMPLE_RATE = 32'd22050;
    localparam logic [29:0]        SFX_AMP     = 30'd12000;
    localparam logic [31:0]        VOL_FULL    = 32'd4095;

    // Serial divider geometry and dividend bit counts per operation
    localparam int DIV_W     = 32;
    localparam int DIV_CNT_W = 6;
    localparam logic [DIV_CNT_W-1:0] NB_FREQ = 6'd25;
    localparam logic [DIV_CNT_W-1:0] NB_PER  = 6'd15;
    localparam logic [DIV_CNT_W-1:0] NB_MOD  = 6'd16;
    localparam logic [DIV_CNT_W-1:0] NB_AMP  = 6'd30;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_VOLUME        = 2'd0,
        REG_EFFECT_LENGTH = 2'd1,
        REG_LOOP_LENGTH   = 2'd2
    } reg_idx_t;

    // Division jobs; all but DOP_VOL run on the shared divider
    typedef enum logic [2:0] {
        DOP_LOOP = 3'd0,
        DOP_FREQ = 3'd1,
        DOP_PER  = 3'd2,
        DOP_MOD  = 3'd3,
        DOP_AMP  = 3'd4,
        DOP_VOL  = 3'd5
    } div_op_t;

    // Controller states
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_DECODE,
        ST_TRIG,
        ST_LOOP_WAIT,
        ST_FX,
        ST_FREQ_GO,
        ST_FREQ_WAIT,
        ST_PER_GO,
        ST_PER_WAIT,
        ST_MOD_GO,
        ST_MOD_WAIT,
        ST_AMP_GO,
        ST_AMP_WAIT,
        ST_MIX,
        ST_MUL,
        ST_VOL_GO,
        ST_VOL_WAIT,
        ST_OUT
    } state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic    capture;
        logic    trig;
        logic    loop_inc;
        logic    div_start;
        logic    div_take;
        div_op_t div_op;
        logic    fx_prep;
        logic    sfx_clr;
        logic    mix_load;
        logic    mul_load;
        logic    vol_est;
        logic    out_load;
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic is_trig;
        logic loop_fast;
        logic fx_active;
        logic div_done;
        logic out_free;
    } sts_t;

endpackage

FILE: hdl/pmsfx_item_if.sv
`timescale 1ns / 1ps
// Input request channel: operation code and music byte.
// Depends on pmsfx_pkg for field widths.
interface pmsfx_item_if;
    logic                           valid;
    logic                           ready;
    logic                           operation;
    logic [pmsfx_pkg::BYTE_W-1:0]   music_byte;

    modport source (output valid, output operation, output music_byte, input ready);
    modport sink   (input valid, input operation, input music_byte, output ready);
endinterface

FILE: hdl/pmsfx_result_if.sv
`timescale 1ns / 1ps
// Output request channel: mixed sample and next fetch address.
// Depends on pmsfx_pkg for field widths.
interface pmsfx_result_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [pmsfx_pkg::SAMPLE_W-1:0] out_sample;
    logic [pmsfx_pkg::ADDR_W-1:0]          next_address;

    modport source (output valid, output out_sample, output next_address, input ready);
    modport sink   (input valid, input out_sample, input next_address, output ready);
endinterface

FILE: hdl/pmsfx_cfg_if.sv
`timescale 1ns / 1ps
// Configuration write channel: register index and write data.
// Depends on pmsfx_pkg for field widths.
interface pmsfx_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [pmsfx_pkg::CFG_IDX_W-1:0]  index;
    logic [pmsfx_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: hdl/pmsfx_div.sv
`timescale 1ns / 1ps
// Shared restoring divider, one quotient bit per cycle, variable dividend length.
// Depends on pmsfx_pkg for widths.
module pmsfx_div
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic [pmsfx_pkg::DIV_W-1:0]         dividend,
    input  logic [pmsfx_pkg::DIV_W-1:0]         divisor,
    input  logic [pmsfx_pkg::DIV_CNT_W-1:0]     nbits,
    output logic                                done,
    output logic [pmsfx_pkg::DIV_W-1:0]         quotient,
    output logic [pmsfx_pkg::DIV_W-1:0]         remainder
);

    localparam int W = pmsfx_pkg::DIV_W;
    localparam int CW = pmsfx_pkg::DIV_CNT_W;

    logic          busy_reg;
    logic [CW-1:0] cnt_reg;
    logic          done_reg;
    logic [W-1:0]  q_reg;
    logic [W-1:0]  r_reg;
    logic [W-1:0]  d_reg;
    logic [W:0]    r_shift;
    logic [W:0]    r_sub;
    logic          fits;

    // Shift in the next dividend bit and trial-subtract
    always_comb
    begin
        r_shift = {r_reg, q_reg[W-1]};
        r_sub   = r_shift - {1'b0, d_reg};
        fits    = (r_shift >= {1'b0, d_reg});
    end

    // Sequence control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == CW'(1));
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= nbits;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1))
                    busy_reg <= 1'b0;
            end
        end
    end

    // Operand load and iteration; align the dividend to the top bit
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg <= dividend << (CW'(W) - nbits);
            r_reg <= '0;
            d_reg <= divisor;
        end
        else if (busy_reg)
        begin
            r_reg <= fits ? r_sub[W-1:0] : r_shift[W-1:0];
            q_reg <= {q_reg[W-2:0], fits};
        end
    end

    assign done      = done_reg;
    assign quotient  = q_reg;
    assign remainder = r_reg;

`ifndef NO_ASSERTIONS
    a_start_idle : assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("divider started while busy");
    a_divisor_nonzero : assert property (@(posedge clk) disable iff (!rst_n)
        start |-> (divisor != '0))
        else $error("divider started with zero divisor");
`endif

endmodule

FILE: hdl/pmsfx_dp.sv
`timescale 1ns / 1ps
// Datapath: configuration registers, loop and effect state, sweep and mix
// arithmetic, output register. Depends on pmsfx_pkg, the channel interfaces, pmsfx_div.
module pmsfx_dp
#(
    parameter int LOOP_MAX = 262144
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  pmsfx_pkg::cmd_t               cmd,
    output pmsfx_pkg::sts_t               sts,
    input  logic                          operation,
    input  logic [pmsfx_pkg::BYTE_W-1:0]  music_byte,
    pmsfx_cfg_if.sink                     cfg,
    pmsfx_result_if.source                result
);

    localparam int PW = $clog2(LOOP_MAX);
    localparam logic [pmsfx_pkg::DIV_CNT_W-1:0] NB_LOOP = pmsfx_pkg::DIV_CNT_W'(PW + 1);
    localparam logic [31:0] LOOP_MAX_W = 32'(LOOP_MAX);

    // Configuration registers
    logic [pmsfx_pkg::VOL_W-1:0]  volume_reg;
    logic [pmsfx_pkg::ELEN_W-1:0] elen_cfg_reg;
    logic [pmsfx_pkg::LLEN_W-1:0] llen_cfg_reg;

    // Item and block state
    logic                 op_reg;
    logic signed [15:0]   music_reg;
    logic [PW-1:0]        pos_reg;
    logic                 armed_reg;
    logic [15:0]          latched_reg;
    logic [15:0]          epos_reg;

    // Effect working registers
    logic [24:0]          freq_num_reg;
    logic [14:0]          freq_div_reg;
    logic                 freq_up_reg;
    logic [29:0]          amp_num_reg;
    logic [9:0]           freq_reg;
    logic [6:0]           period_reg;
    logic                 sq_pos_reg;
    logic signed [15:0]   sfx_reg;
    logic signed [15:0]   mix_reg;
    logic                 mix_neg_reg;
    logic [27:0]          prod_reg;
    logic [16:0]          vest_reg;
    logic signed [15:0]   res_reg;

    // Output register
    logic                 out_valid_reg;
    logic signed [15:0]   out_sample_reg;
    logic [pmsfx_pkg::ADDR_W-1:0] out_addr_reg;

    // Combinational helpers
    logic [31:0]          len_clamp;
    logic [31:0]          pos_inc;
    logic [31:0]          pos_wide;
    logic [14:0]          half;
    logic                 half_zero;
    logic                 up;
    logic [15:0]          fdelta;
    logic signed [8:0]    centered;
    logic signed [16:0]   music_full;
    logic signed [16:0]   mix_sum;
    logic signed [16:0]   mix_ext;
    logic [16:0]          mix_mag;
    logic [28:0]          vsum;
    logic [28:0]          vrem;
    logic [16:0]          vquo;
    logic [15:0]          quo16;
    logic [pmsfx_pkg::DIV_W-1:0]     div_a;
    logic [pmsfx_pkg::DIV_W-1:0]     div_b;
    logic [pmsfx_pkg::DIV_CNT_W-1:0] div_n;
    logic                            div_done;
    logic [pmsfx_pkg::DIV_W-1:0]     div_quo;
    logic [pmsfx_pkg::DIV_W-1:0]     div_rem;

    assign cfg.ready = 1'b1;

    // Take configuration writes; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            volume_reg   <= pmsfx_pkg::VOLUME_RESET;
            elen_cfg_reg <= pmsfx_pkg::EFFECT_LENGTH_RESET;
            llen_cfg_reg <= pmsfx_pkg::LOOP_LENGTH_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                pmsfx_pkg::REG_VOLUME:        volume_reg   <= cfg.data[pmsfx_pkg::VOL_W-1:0];
                pmsfx_pkg::REG_EFFECT_LENGTH: elen_cfg_reg <= cfg.data[pmsfx_pkg::ELEN_W-1:0];
                pmsfx_pkg::REG_LOOP_LENGTH:   llen_cfg_reg <= cfg.data[pmsfx_pkg::LLEN_W-1:0];
                default: ;
            endcase
        end
    end

    // Clamp the loop length to 1..LOOP_MAX and find the next position
    always_comb
    begin
        if (llen_cfg_reg == '0)
            len_clamp = 32'd1;
        else if (32'(llen_cfg_reg) > LOOP_MAX_W)
            len_clamp = LOOP_MAX_W;
        else
            len_clamp = 32'(llen_cfg_reg);
        pos_inc  = 32'(pos_reg) + 32'd1;
        pos_wide = 32'(pos_reg);
    end

    // Sweep geometry and music scaling
    always_comb
    begin
        half       = latched_reg[15:1];
        half_zero  = (half == '0);
        up         = (epos_reg < {1'b0, half});
        fdelta     = up ? epos_reg : (epos_reg - {1'b0, half});
        centered   = $signed({1'b0, music_byte}) - pmsfx_pkg::MUSIC_BIAS;
        music_full = 17'(centered) * pmsfx_pkg::MUSIC_GAIN;
        mix_sum    = 17'(music_reg) + 17'(sfx_reg);
        mix_ext    = 17'(mix_reg);
        mix_mag    = mix_reg[15] ? 17'(-mix_ext) : 17'(mix_ext);
    end

    // Divide the scaled magnitude by 4095: estimate low by at most one, then correct
    always_comb
    begin
        vsum  = 29'(prod_reg) + 29'(prod_reg[27:12]) + 29'(prod_reg[27:24]);
        vrem  = 29'(prod_reg) + 29'(vest_reg) - {vest_reg, 12'd0};
        vquo  = vest_reg + 17'(vrem >= 29'(pmsfx_pkg::VOL_FULL));
        quo16 = vquo[15:0];
    end

    // Select divider operands for the current job
    always_comb
    begin
        unique case (cmd.div_op)
            pmsfx_pkg::DOP_LOOP:
            begin
                div_a = pos_inc;
                div_b = len_clamp;
                div_n = NB_LOOP;
            end
            pmsfx_pkg::DOP_FREQ:
            begin
                div_a = 32'(freq_num_reg);
                div_b = 32'(freq_div_reg);
                div_n = pmsfx_pkg::NB_FREQ;
            end
            pmsfx_pkg::DOP_PER:
            begin
                div_a = pmsfx_pkg::SAMPLE_RATE;
                div_b = 32'(freq_reg);
                div_n = pmsfx_pkg::NB_PER;
            end
            pmsfx_pkg::DOP_MOD:
            begin
                div_a = 32'(epos_reg);
                div_b = 32'(period_reg);
                div_n = pmsfx_pkg::NB_MOD;
            end
            pmsfx_pkg::DOP_AMP:
            begin
                div_a = 32'(amp_num_reg);
                div_b = 32'(latched_reg);
                div_n = pmsfx_pkg::NB_AMP;
            end
            default:
            begin
                div_a = '0;
                div_b = 32'd1;
                div_n = pmsfx_pkg::NB_MOD;
            end
        endcase
    end

    pmsfx_div u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  (div_a),
        .divisor   (div_b),
        .nbits     (div_n),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // Loop position and effect state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= '0;
            armed_reg   <= 1'b0;
            latched_reg <= '0;
            epos_reg    <= '0;
        end
        else
        begin
            if (cmd.trig)
            begin
                armed_reg   <= 1'b1;
                latched_reg <= elen_cfg_reg;
                epos_reg    <= '0;
            end
            if (cmd.loop_inc)
                pos_reg <= pos_inc[PW-1:0];
            if (cmd.div_take && cmd.div_op == pmsfx_pkg::DOP_LOOP)
                pos_reg <= div_rem[PW-1:0];
            if (cmd.div_take && cmd.div_op == pmsfx_pkg::DOP_AMP)
                epos_reg <= epos_reg + 16'd1;
        end
    end

    // Capture the item and run the effect and mix arithmetic
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg    <= operation;
            music_reg <= music_full[15:0];
        end
        if (cmd.fx_prep)
        begin
            freq_num_reg <= 25'(fdelta) * pmsfx_pkg::FREQ_SPAN;
            freq_div_reg <= half_zero ? 15'd1 : half;
            freq_up_reg  <= up || half_zero;
            amp_num_reg  <= 30'(latched_reg - epos_reg) * pmsfx_pkg::SFX_AMP;
        end
        if (cmd.div_take)
        begin
            unique case (cmd.div_op)
                pmsfx_pkg::DOP_FREQ:
                    freq_reg <= freq_up_reg ? (pmsfx_pkg::FREQ_LOW + div_quo[9:0])
                                            : (pmsfx_pkg::FREQ_HIGH - div_quo[9:0]);
                pmsfx_pkg::DOP_PER:
                    period_reg <= div_quo[6:0];
                pmsfx_pkg::DOP_MOD:
                    sq_pos_reg <= (div_rem[6:0] < (period_reg >> 1));
                pmsfx_pkg::DOP_AMP:
                    sfx_reg <= sq_pos_reg ? $signed(16'(div_quo[13:0]))
                                          : -$signed(16'(div_quo[13:0]));
                pmsfx_pkg::DOP_VOL:
                    res_reg <= mix_neg_reg ? $signed(16'(-quo16)) : $signed(quo16);
                default: ;
            endcase
        end
        if (cmd.sfx_clr)
            sfx_reg <= '0;
        if (cmd.mix_load)
            mix_reg <= mix_sum[15:0];
        if (cmd.mul_load)
        begin
            mix_neg_reg <= mix_reg[15];
            prod_reg    <= 28'(mix_mag) * 28'(volume_reg);
        end
        if (cmd.vol_est)
            vest_reg <= vsum[28:12];
        if (cmd.trig)
            res_reg <= '0;
    end

    // Output register: hold the result until the sink takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_load)
            out_valid_reg <= 1'b1;
        else if (result.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_sample_reg <= res_reg;
            out_addr_reg   <= pos_wide[pmsfx_pkg::ADDR_W-1:0];
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.out_sample   = out_sample_reg;
    assign result.next_address = out_addr_reg;

    // Status back to the controller
    always_comb
    begin
        sts.is_trig   = op_reg;
        sts.loop_fast = (pos_inc < len_clamp);
        sts.fx_active = armed_reg && (epos_reg < latched_reg);
        sts.div_done  = div_done;
        sts.out_free  = !out_valid_reg || result.ready;
    end

`ifndef NO_ASSERTIONS
    a_pos_in_loop : assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.out_load && !op_reg) |-> (32'(pos_reg) < len_clamp))
        else $error("loop position outside loop length");
    a_period_range : assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.div_take && cmd.div_op == pmsfx_pkg::DOP_PER)
            |-> (div_quo >= 32'd22 && div_quo <= 32'd110))
        else $error("square wave period out of range");
`endif

endmodule

FILE: hdl/pmsfx_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine: sequences the divider jobs and the mix for each tick request.
// Depends on pmsfx_pkg for states, commands and status.
module pmsfx_ctrl
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            item_valid,
    output logic            item_ready,
    input  pmsfx_pkg::sts_t sts,
    output pmsfx_pkg::cmd_t cmd
);

    pmsfx_pkg::state_t state_reg;
    pmsfx_pkg::state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= pmsfx_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            pmsfx_pkg::ST_IDLE:
                if (item_valid)
                    state_next = pmsfx_pkg::ST_DECODE;
            pmsfx_pkg::ST_DECODE:
                if (sts.is_trig)
                    state_next = pmsfx_pkg::ST_TRIG;
                else if (sts.loop_fast)
                    state_next = pmsfx_pkg::ST_FX;
                else
                    state_next = pmsfx_pkg::ST_LOOP_WAIT;
            pmsfx_pkg::ST_TRIG:
                state_next = pmsfx_pkg::ST_OUT;
            pmsfx_pkg::ST_LOOP_WAIT:
                if (sts.div_done)
                    state_next = pmsfx_pkg::ST_FX;
            pmsfx_pkg::ST_FX:
                state_next = sts.fx_active ? pmsfx_pkg::ST_FREQ_GO : pmsfx_pkg::ST_MIX;
            pmsfx_pkg::ST_FREQ_GO:
                state_next = pmsfx_pkg::ST_FREQ_WAIT;
            pmsfx_pkg::ST_FREQ_WAIT:
                if (sts.div_done)
                    state_next = pmsfx_pkg::ST_PER_GO;
            pmsfx_pkg::ST_PER_GO:
                state_next = pmsfx_pkg::ST_PER_WAIT;
            pmsfx_pkg::ST_PER_WAIT:
                if (sts.div_done)
                    state_next = pmsfx_pkg::ST_MOD_GO;
            pmsfx_pkg::ST_MOD_GO:
                state_next = pmsfx_pkg::ST_MOD_WAIT;
            pmsfx_pkg::ST_MOD_WAIT:
                if (sts.div_done)
                    state_next = pmsfx_pkg::ST_AMP_GO;
            pmsfx_pkg::ST_AMP_GO:
                state_next = pmsfx_pkg::ST_AMP_WAIT;
            pmsfx_pkg::ST_AMP_WAIT:
                if (sts.div_done)
                    state_next = pmsfx_pkg::ST_MIX;
            pmsfx_pkg::ST_MIX:
                state_next = pmsfx_pkg::ST_MUL;
            pmsfx_pkg::ST_MUL:
                state_next = pmsfx_pkg::ST_VOL_GO;
            pmsfx_pkg::ST_VOL_GO:
                state_next = pmsfx_pkg::ST_VOL_WAIT;
            pmsfx_pkg::ST_VOL_WAIT:
                state_next = pmsfx_pkg::ST_OUT;
            pmsfx_pkg::ST_OUT:
                if (sts.out_free)
                    state_next = pmsfx_pkg::ST_IDLE;
            default:
                state_next = pmsfx_pkg::ST_IDLE;
        endcase
    end

    // Commands
    always_comb
    begin
        cmd        = '0;
        item_ready = 1'b0;
        unique case (state_reg)
            pmsfx_pkg::ST_IDLE:
            begin
                item_ready  = 1'b1;
                cmd.capture = item_valid;
            end
            pmsfx_pkg::ST_DECODE:
            begin
                cmd.div_op = pmsfx_pkg::DOP_LOOP;
                if (!sts.is_trig)
                begin
                    cmd.loop_inc  = sts.loop_fast;
                    cmd.div_start = !sts.loop_fast;
                end
            end
            pmsfx_pkg::ST_TRIG:
                cmd.trig = 1'b1;
            pmsfx_pkg::ST_LOOP_WAIT:
            begin
                cmd.div_op   = pmsfx_pkg::DOP_LOOP;
                cmd.div_take = sts.div_done;
            end
            pmsfx_pkg::ST_FX:
            begin
                cmd.fx_prep = sts.fx_active;
                cmd.sfx_clr = !sts.fx_active;
            end
            pmsfx_pkg::ST_FREQ_GO:
            begin
                cmd.div_op    = pmsfx_pkg::DOP_FREQ;
                cmd.div_start = 1'b1;
            end
            pmsfx_pkg::ST_FREQ_WAIT:
            begin
                cmd.div_op   = pmsfx_pkg::DOP_FREQ;
                cmd.div_take = sts.div_done;
            end
            pmsfx_pkg::ST_PER_GO:
            begin
                cmd.div_op    = pmsfx_pkg::DOP_PER;
                cmd.div_start = 1'b1;
            end
            pmsfx_pkg::ST_PER_WAIT:
            begin
                cmd.div_op   = pmsfx_pkg::DOP_PER;
                cmd.div_take = sts.div_done;
            end
            pmsfx_pkg::ST_MOD_GO:
            begin
                cmd.div_op    = pmsfx_pkg::DOP_MOD;
                cmd.div_start = 1'b1;
            end
            pmsfx_pkg::ST_MOD_WAIT:
            begin
                cmd.div_op   = pmsfx_pkg::DOP_MOD;
                cmd.div_take = sts.div_done;
            end
            pmsfx_pkg::ST_AMP_GO:
            begin
                cmd.div_op    = pmsfx_pkg::DOP_AMP;
                cmd.div_start = 1'b1;
            end
            pmsfx_pkg::ST_AMP_WAIT:
            begin
                cmd.div_op   = pmsfx_pkg::DOP_AMP;
                cmd.div_take = sts.div_done;
            end
            pmsfx_pkg::ST_MIX:
                cmd.mix_load = 1'b1;
            pmsfx_pkg::ST_MUL:
                cmd.mul_load = 1'b1;
            // Estimate the volume quotient, then correct and take it
            pmsfx_pkg::ST_VOL_GO:
                cmd.vol_est = 1'b1;
            pmsfx_pkg::ST_VOL_WAIT:
            begin
                cmd.div_op   = pmsfx_pkg::DOP_VOL;
                cmd.div_take = 1'b1;
            end
            pmsfx_pkg::ST_OUT:
                cmd.out_load = sts.out_free;
            default: ;
        endcase
    end

`ifndef NO_ASSERTIONS
    a_take_ends_wait : assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_take |=> (state_reg != pmsfx_pkg::ST_LOOP_WAIT
                          && state_reg != pmsfx_pkg::ST_VOL_WAIT))
        else $error("controller stayed in a wait state after divider result");
`endif

endmodule

FILE: hdl/pcm_mixer_with_sweep_sfx_unit.sv
`timescale 1ns / 1ps
// Top level of the PCM mixer with sweep sound effect: controller plus datapath.
// Depends on pmsfx_pkg, the channel interfaces, pmsfx_ctrl and pmsfx_dp.
//
//   channel  | role  | payload
//   ---------+-------+------------------------------------------
//   item     | sink  | operation, music_byte
//   result   | source| out_sample, next_address
//   cfg      | sink  | index (0 volume, 1 effect_length, 2 loop_length), data
//
// One request at a time. A tick with an effect playing runs the four divider jobs of
// the sweep, each at one quotient bit per cycle; a tick that wraps the loop runs one
// more divider job for the loop position first.
// Reset clears the loop and effect state and loads the register defaults.
// The output register holds a result while the sink stalls; the next request is
// accepted meanwhile and waits in its last step only if the register is still full.
module pcm_mixer_with_sweep_sfx_unit
#(
    parameter int LOOP_MAX = 262144
)
(
    input  logic            clk,
    input  logic            rst_n,
    pmsfx_item_if.sink      item,
    pmsfx_result_if.source  result,
    pmsfx_cfg_if.sink       cfg
);

    pmsfx_pkg::cmd_t cmd;
    pmsfx_pkg::sts_t sts;
    logic            item_ready;

    assign item.ready = item_ready;

    pmsfx_ctrl u_ctrl
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item.valid),
        .item_ready (item_ready),
        .sts        (sts),
        .cmd        (cmd)
    );

    pmsfx_dp
    #(
        .LOOP_MAX (LOOP_MAX)
    )
    u_dp
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .operation  (item.operation),
        .music_byte (item.music_byte),
        .cfg        (cfg),
        .result     (result)
    );

endmodule

FILE: tb/pcm_mixer_with_sweep_sfx_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for pcm_mixer_with_sweep_sfx_unit: directed and random requests,
// checked against a sample predictor in a scoreboard class, the random ones under random gaps and stalls.
// Depends on pmsfx_pkg, the item/result/cfg channel interfaces and the RTL top level.

localparam logic OP_TICK    = 1'b0;
localparam logic OP_TRIGGER = 1'b1;

// Predicts mixed samples and fetch addresses, and checks results in order
class mixer_scoreboard;
    typedef struct packed {
        logic signed [pmsfx_pkg::SAMPLE_W-1:0] sample;
        logic [pmsfx_pkg::ADDR_W-1:0]          addr;
    } mix_result_t;

    int unsigned                  loop_max;
    logic [pmsfx_pkg::VOL_W-1:0]  volume;
    logic [pmsfx_pkg::ELEN_W-1:0] effect_length;
    logic [pmsfx_pkg::LLEN_W-1:0] loop_length;
    logic [pmsfx_pkg::ADDR_W-1:0] loop_pos;
    logic [pmsfx_pkg::ELEN_W-1:0] fx_pos;
    logic [pmsfx_pkg::ELEN_W-1:0] fx_len;
    logic                         fx_armed;
    mix_result_t                  expected_q[$];
    int                           errors;
    int                           ticks;
    int                           triggers;
    int                           fx_samples;
    int                           wraps;

    function new(int unsigned loop_max_value);
        loop_max      = loop_max_value;
        volume        = pmsfx_pkg::VOLUME_RESET;
        effect_length = pmsfx_pkg::EFFECT_LENGTH_RESET;
        loop_length   = pmsfx_pkg::LOOP_LENGTH_RESET;
        loop_pos      = '0;
        fx_pos        = '0;
        fx_len        = '0;
        fx_armed      = 1'b0;
        errors        = 0;
        ticks         = 0;
        triggers      = 0;
        fx_samples    = 0;
        wraps         = 0;
    endfunction

    function void set_register(pmsfx_pkg::reg_idx_t idx,
                               logic [pmsfx_pkg::CFG_DATA_W-1:0] data);
        case (idx)
            pmsfx_pkg::REG_VOLUME:        volume        = data[pmsfx_pkg::VOL_W-1:0];
            pmsfx_pkg::REG_EFFECT_LENGTH: effect_length = data[pmsfx_pkg::ELEN_W-1:0];
            pmsfx_pkg::REG_LOOP_LENGTH:   loop_length   = data[pmsfx_pkg::LLEN_W-1:0];
            default: ;
        endcase
    endfunction

    // Square wave with swept frequency and linear fade at the current effect position
    function int sweep_sample();
        int unsigned p;
        int unsigned len;
        int unsigned half;
        int unsigned freq;
        int unsigned period;
        int          sq;
        p    = fx_pos;
        len  = fx_len;
        half = len / 2;
        if (half == 0)
            freq = 200;
        else if (p < half)
            freq = 200 + p * 800 / half;
        else
            freq = 1000 - (p - half) * 800 / half;
        period = 22050 / freq;
        sq = ((p % period) < period / 2) ? 12000 : -12000;
        return int'(longint'(sq) * longint'(len - p) / longint'(len));
    endfunction

    function void note_request(logic op, logic [pmsfx_pkg::BYTE_W-1:0] music_byte);
        mix_result_t             r;
        int                      music;
        int                      sfx;
        int unsigned             span;
        logic signed [15:0]      wrapped;
        longint                  scaled;
        // Trigger: restart the effect, hold the loop position
        if (op == OP_TRIGGER)
        begin
            triggers++;
            fx_armed = 1'b1;
            fx_len   = effect_length;
            fx_pos   = '0;
            r.sample = '0;
            r.addr   = loop_pos;
            expected_q.push_back(r);
            return;
        end
        ticks++;
        music = (int'(music_byte) - 128) * 200;
        // Advance the loop with a clamped length
        span = loop_length;
        if (span == 0)
            span = 1;
        if (span > loop_max)
            span = loop_max;
        loop_pos = pmsfx_pkg::ADDR_W'((int'(loop_pos) + 1) % span);
        if (loop_pos == 0)
            wraps++;
        // Add the effect while it has samples left
        sfx = 0;
        if (fx_armed && fx_pos < fx_len)
        begin
            sfx = sweep_sample();
            fx_pos = fx_pos + 1'b1;
            fx_samples++;
        end
        wrapped  = 16'(music + sfx);
        scaled   = longint'(wrapped) * longint'(volume) / longint'(4095);
        r.sample = scaled[15:0];
        r.addr   = loop_pos;
        expected_q.push_back(r);
    endfunction

    function void check_result(logic signed [pmsfx_pkg::SAMPLE_W-1:0] sample,
                               logic [pmsfx_pkg::ADDR_W-1:0] addr);
        mix_result_t want;
        if (expected_q.size() == 0)
        begin
            errors++;
            $display("%0t: result with nothing pending: out_sample %0d next_address %0d",
                     $time, sample, addr);
            return;
        end
        want = expected_q.pop_front();
        if (sample !== want.sample)
        begin
            errors++;
            $display("%0t: out_sample expected %0d actual %0d", $time, want.sample, sample);
        end
        if (addr !== want.addr)
        begin
            errors++;
            $display("%0t: next_address expected %0d actual %0d", $time, want.addr, addr);
        end
    endfunction

    function int pending();
        return expected_q.size();
    endfunction
endclass

module pcm_mixer_with_sweep_sfx_unit_tb;
    import pmsfx_pkg::*;

    localparam int LOOP_LIMIT   = 262144;
    localparam int PHASES       = 12;
    localparam int PHASE_ITEMS  = 75;
    localparam int QUIET_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 300;

    logic            clk = 1'b0;
    logic            rst_n = 1'b0;
    int              send_idle_pct = 0;
    int              sink_stall_pct = 0;
    int              quiet_cycles = 0;
    mixer_scoreboard board;

    pmsfx_item_if   item();
    pmsfx_result_if result();
    pmsfx_cfg_if    cfg();

    pcm_mixer_with_sweep_sfx_unit #(.LOOP_MAX(LOOP_LIMIT)) uut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .result (result),
        .cfg    (cfg)
    );

    always #4 clk = ~clk;

    // Stall the result sink at random
    always @(posedge clk)
        result.ready <= (sink_stall_pct == 0) || ($urandom_range(0, 99) >= sink_stall_pct);

    // Track register writes, check results, predict accepted requests
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg.valid && cfg.ready)
                board.set_register(reg_idx_t'(cfg.index), cfg.data);
            if (result.valid && result.ready)
                board.check_result(result.out_sample, result.next_address);
            if (item.valid && item.ready)
                board.note_request(item.operation, item.music_byte);
        end
    end

    // Watchdog: end the run when no channel moves for too long
    always @(posedge clk)
    begin
        if ((item.valid && item.ready) || (result.valid && result.ready)
            || (cfg.valid && cfg.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
            $display("pcm_mixer_with_sweep_sfx_unit_tb NOT OK");
            $finish;
        end
    end

    // Offer one request, with random gaps ahead of it, and hold until accepted
    task automatic send_request(input logic op, input logic [BYTE_W-1:0] music_byte);
        while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct)
        begin
            item.valid      <= 1'b0;
            item.operation  <= 1'($urandom);
            item.music_byte <= 8'($urandom);
            @(posedge clk);
        end
        item.valid      <= 1'b1;
        item.operation  <= op;
        item.music_byte <= music_byte;
        do @(posedge clk); while (!item.ready);
    endtask

    // Drop valid and wait until every predicted result has come back
    task automatic finish_burst();
        item.valid <= 1'b0;
        @(posedge clk);
        while (board.pending() != 0)
            @(posedge clk);
    endtask

    task automatic put_register(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= data;
        do @(posedge clk); while (!cfg.ready);
    endtask

    task automatic write_registers(input logic [VOL_W-1:0] vol,
                                   input logic [ELEN_W-1:0] elen,
                                   input logic [LLEN_W-1:0] llen);
        put_register(REG_VOLUME, CFG_DATA_W'(vol));
        put_register(REG_EFFECT_LENGTH, CFG_DATA_W'(elen));
        put_register(REG_LOOP_LENGTH, llen);
        cfg.valid <= 1'b0;
    endtask

    initial
    begin
        logic [VOL_W-1:0]  vol;
        logic [ELEN_W-1:0] elen;
        logic [LLEN_W-1:0] llen;
        board = new(LOOP_LIMIT);
        item.valid      = 1'b0;
        item.operation  = OP_TICK;
        item.music_byte = '0;
        cfg.valid       = 1'b0;
        cfg.index       = REG_VOLUME;
        cfg.data        = '0;
        result.ready    = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: byte extremes with no effect, then a default effect
        send_request(OP_TICK, 8'd0);
        send_request(OP_TICK, 8'd255);
        send_request(OP_TICK, 8'd128);
        send_request(OP_TRIGGER, 8'd0);
        send_request(OP_TICK, 8'd1);
        send_request(OP_TICK, 8'd254);
        send_request(OP_TICK, 8'h55);
        send_request(OP_TICK, 8'hAA);
        finish_burst();

        // Full volume, one-sample effect, zero loop length
        write_registers(12'd4095, 16'd1, 19'd0);
        send_request(OP_TRIGGER, 8'hFF);
        send_request(OP_TICK, 8'd255);
        send_request(OP_TICK, 8'd0);
        finish_burst();

        // Mute, effect that never plays, loop length above the maximum
        write_registers(12'd0, 16'd0, 19'h7FFFF);
        send_request(OP_TRIGGER, 8'd0);
        send_request(OP_TICK, 8'd77);
        send_request(OP_TICK, 8'd200);
        finish_burst();

        // Music plus effect overflowing 16 bits, one-byte loop
        write_registers(12'd4095, 16'd2, 19'd1);
        send_request(OP_TRIGGER, 8'd0);
        send_request(OP_TICK, 8'd255);
        send_request(OP_TICK, 8'd255);
        send_request(OP_TICK, 8'd0);
        finish_burst();

        // Longest effect restarted while playing, loop at its maximum length
        write_registers(12'd2000, 16'd65535, 19'd262144);
        send_request(OP_TRIGGER, 8'd0);
        send_request(OP_TICK, 8'd3);
        send_request(OP_TRIGGER, 8'd0);
        send_request(OP_TICK, 8'd252);
        finish_burst();

        // Random phases: new settings each time, idling mode rotates
        for (int ph = 0; ph < PHASES; ph++)
        begin
            if (ph == 1)
                vol = '0;
            else if (ph % 3 == 0)
                vol = 12'd4095;
            else
                vol = 12'($urandom_range(0, 4095));
            case (ph)
                4:       elen = 16'd65535;
                6:       elen = 16'd1;
                8:       elen = 16'd0;
                10:      elen = 16'($urandom_range(2, 65535));
                default: elen = 16'($urandom_range(2, 48));
            endcase
            case (ph)
                2:       llen = 19'd262144;
                3:       llen = 19'd0;
                5:       llen = 19'($urandom_range(262145, 524287));
                9:       llen = 19'd1;
                11:      llen = 19'($urandom_range(1, 262144));
                default: llen = 19'($urandom_range(1, 40));
            endcase
            write_registers(vol, elen, llen);
            case (ph % 4)
                0:       begin send_idle_pct = 0;  sink_stall_pct = 0;  end
                1:       begin send_idle_pct = 49; sink_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  sink_stall_pct = 49; end
                default: begin send_idle_pct = 22; sink_stall_pct = 22; end
            endcase
            for (int k = 0; k < PHASE_ITEMS; k++)
                send_request(($urandom_range(0, 99) < 7) ? OP_TRIGGER : OP_TICK,
                             8'($urandom));
            finish_burst();
        end

        send_idle_pct  = 0;
        sink_stall_pct = 0;
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Checked %0d ticks and %0d triggers over 5 directed and %0d random phases,",
                 board.ticks, board.triggers, PHASES);
        $display("with %0d effect samples mixed and %0d loop wraps.",
                 board.fx_samples, board.wraps);
        if (board.errors == 0 && board.pending() == 0)
            $display("pcm_mixer_with_sweep_sfx_unit_tb OK");
        else
            $display("pcm_mixer_with_sweep_sfx_unit_tb NOT OK");
        $finish;
    end

endmodule
